// ===== rtl/sfr_pkg.sv =====
// Shared types, codes and the CRC update function of the stuffed frame receiver.
package sfr_pkg;

    localparam logic [7:0] MARK_START  = 8'hB4;
    localparam logic [7:0] MARK_ESC    = 8'hB5;
    localparam logic [7:0] MARK_TSTART = 8'hB6;
    localparam logic [7:0] MARK_TESC   = 8'hB7;

    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [0:0] {
        CFG_POLY = 1'b0,
        CFG_REFL = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_CONSUMED = 3'd0,
        EV_PASS     = 3'd1,
        EV_PAYLOAD  = 3'd2,
        EV_GOOD     = 3'd3,
        EV_CRC_ERR  = 3'd4,
        EV_ABORT    = 3'd5
    } t_event;

    // Commands handed from the front to the back.
    typedef enum logic [2:0] {
        OP_CONSUME = 3'd0,
        OP_PASS    = 3'd1,
        OP_SEED    = 3'd2,
        OP_CRC     = 3'd3,
        OP_PAYLOAD = 3'd4,
        OP_CHECK   = 3'd5,
        OP_ABORT   = 3'd6
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [15:0] idx;
        logic [15:0] len;
        logic [15:0] rcrc;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly, input logic refl);
        logic [15:0] c;
        if (refl) begin
            c = crc ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                if (c[0]) c = (c >> 1) ^ poly;
                else      c = c >> 1;
            end
        end else begin
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                if (c[15]) c = (c << 1) ^ poly;
                else       c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/sfr_front.sv =====
// Front end: destuffing and frame parsing, one command per received byte.
module sfr_front
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN0 = 3'd1,
        PH_LEN1 = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC0 = 3'd4,
        PH_CRC1 = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [7:0]  d;
    logic        esc_ok;

    always_comb begin
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_len    = r_len;
        n_count  = r_count;
        n_crc_lo = r_crc_lo;
        o_cmd    = '{op: OP_CONSUME, data: 8'h00, idx: 16'h0000, len: 16'h0000,
                     rcrc: 16'h0000};
        d        = i_byte;
        esc_ok   = 1'b1;

        if (i_byte == MARK_START) begin
            n_prev     = i_byte;
            n_phase    = PH_LEN0;
            o_cmd.op   = OP_SEED;
            o_cmd.data = i_byte;
        end else if (r_phase == PH_IDLE) begin
            o_cmd.op   = OP_PASS;
            o_cmd.data = i_byte;
        end else begin
            n_prev = i_byte;
            if (r_prev == MARK_ESC) begin
                if (i_byte == MARK_TESC)        d = MARK_ESC;
                else if (i_byte == MARK_TSTART) d = MARK_START;
                else                            esc_ok = 1'b0;
            end

            if (!esc_ok) begin
                n_phase  = PH_IDLE;
                o_cmd.op = OP_ABORT;
            end else if (r_prev != MARK_ESC && i_byte == MARK_ESC) begin
                o_cmd.op = OP_CONSUME;
            end else begin
                case (r_phase)
                    PH_LEN0: begin
                        o_cmd.op   = OP_CRC;
                        o_cmd.data = d;
                        n_len      = {8'h00, d};
                        n_phase    = PH_LEN1;
                    end
                    PH_LEN1: begin
                        o_cmd.op   = OP_CRC;
                        o_cmd.data = d;
                        n_count    = 16'h0000;
                        n_len      = {d, r_len[7:0]};
                        n_phase    = ({d, r_len[7:0]} != 16'h0000) ? PH_DATA : PH_CRC0;
                    end
                    PH_DATA: begin
                        o_cmd.op   = OP_PAYLOAD;
                        o_cmd.data = d;
                        o_cmd.idx  = r_count;
                        o_cmd.len  = r_len;
                        n_count    = r_count + 16'd1;
                        if (n_count >= r_len) n_phase = PH_CRC0;
                    end
                    PH_CRC0: begin
                        n_crc_lo = d;
                        n_phase  = PH_CRC1;
                    end
                    PH_CRC1: begin
                        o_cmd.op   = OP_CHECK;
                        o_cmd.len  = r_len;
                        o_cmd.rcrc = {d, r_crc_lo};
                        n_phase    = PH_IDLE;
                    end
                    default: begin
                        o_cmd.op = OP_CONSUME;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_prev   <= 8'h00;
            r_len    <= 16'h0000;
            r_count  <= 16'h0000;
            r_crc_lo <= 8'h00;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

// ===== rtl/sfr_queue.sv =====
// Short command queue between the front and the back.
module sfr_queue
    import sfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_ctrl   i_ctrl,
    input  t_cmd      i_cmd,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_ctrl.pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_ctrl.push, i_ctrl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/sfr_back.sv =====
// Back end: running CRC, configuration registers and the result register.
module sfr_back
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_out,
    output logic [15:0] o_byte_index,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc
);

    logic [15:0] r_poly;
    logic        r_refl;
    logic [15:0] r_crc, n_crc;
    logic        r_valid;
    t_event      n_event;
    logic [7:0]  n_data;
    logic [15:0] n_idx, n_len, n_rcrc, n_ccrc;
    logic [15:0] crc_in;

    assign o_pop   = !i_q_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    // A start marker seeds the CRC from zero.
    assign crc_in  = (i_cmd.op == OP_SEED) ? 16'h0000 : r_crc;

    always_comb begin
        n_crc   = r_crc;
        n_event = EV_CONSUMED;
        n_data  = 8'h00;
        n_idx   = 16'h0000;
        n_len   = 16'h0000;
        n_rcrc  = 16'h0000;
        n_ccrc  = 16'h0000;
        case (i_cmd.op)
            OP_PASS: begin
                n_event = EV_PASS;
                n_data  = i_cmd.data;
            end
            OP_SEED, OP_CRC: begin
                n_crc = crc_update(crc_in, i_cmd.data, r_poly, r_refl);
            end
            OP_PAYLOAD: begin
                n_crc   = crc_update(crc_in, i_cmd.data, r_poly, r_refl);
                n_event = EV_PAYLOAD;
                n_data  = i_cmd.data;
                n_idx   = i_cmd.idx;
                n_len   = i_cmd.len;
            end
            OP_CHECK: begin
                n_event = (r_crc == i_cmd.rcrc) ? EV_GOOD : EV_CRC_ERR;
                n_len   = i_cmd.len;
                n_rcrc  = i_cmd.rcrc;
                n_ccrc  = r_crc;
            end
            OP_ABORT: begin
                n_event = EV_ABORT;
            end
            default: begin
                n_event = EV_CONSUMED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= CRC_POLY_RESET;
            r_refl  <= 1'b0;
            r_crc   <= 16'h0000;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_POLY: r_poly <= i_cfg_data;
                    CFG_REFL: r_refl <= i_cfg_data[0];
                    default:  r_poly <= r_poly;
                endcase
            end
            if (o_pop) begin
                r_crc   <= n_crc;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_event_res    <= n_event;
            o_data_out     <= n_data;
            o_byte_index   <= n_idx;
            o_frame_length <= n_len;
            o_received_crc <= n_rcrc;
            o_computed_crc <= n_ccrc;
        end
    end

endmodule

// ===== rtl/stuffed_frame_receiver_unit.sv =====
// Top level of the stuffed frame receiver: front parser, command queue and CRC back end.
// A byte accepted by the front is written into the command queue; the back end pops it when
// the result register is empty or not stalled, and registers its result on the outputs.
// Throughput: one byte per cycle while o_stall is low; the two-entry command queue
// absorbs output stalls. The back end updates its CRC register over all eight bits at once.
// Reset (synchronous, active low) returns to waiting for a start marker, empties the
// queue and the result register, and restores polynomial 0x1021, MSB-first.
module stuffed_frame_receiver_unit
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_out,
    output logic [15:0] o_byte_index,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc
);

    t_cmd      front_cmd, q_cmd;
    t_q_ctrl   q_ctrl;
    t_q_status q_status;
    logic      accept;
    logic      pop;

    assign o_stall     = q_status.full;
    assign accept      = i_valid && !q_status.full;
    assign q_ctrl.push = accept;
    assign q_ctrl.pop  = pop;

    sfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_rx_byte),
        .o_cmd    (front_cmd)
    );

    sfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (q_ctrl),
        .i_cmd    (front_cmd),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    sfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_empty      (q_status.empty),
        .i_cmd          (q_cmd),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_event_res    (o_event_res),
        .o_data_out     (o_data_out),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_received_crc (o_received_crc),
        .o_computed_crc (o_computed_crc)
    );

endmodule
